// File: rtl/kts_pkg.sv
// shared types and constants for the keyframe track sampler
`timescale 1ns / 1ps
package kts_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_AW    = $clog2(MAX_KEYS);
	localparam int VEC_DEPTH = 3 * MAX_KEYS;
	localparam int VEC_AW    = $clog2(VEC_DEPTH);
	localparam int FRAC_BITS = 16;
	localparam int CNT_W     = 7;

	// configuration register indexes
	localparam logic [1:0] REG_INTERP_MODE  = 2'd0;
	localparam logic [1:0] REG_KEY_COUNT    = 2'd1;
	localparam logic [1:0] REG_CHANNEL_KIND = 2'd2;

	// interpolation modes
	localparam logic [1:0] MODE_STEP  = 2'd0;
	localparam logic [1:0] MODE_CUBIC = 2'd2;

	// request kinds and key parts
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
	localparam logic [1:0] PART_IN    = 2'd0;
	localparam logic [1:0] PART_VALUE = 2'd1;
	localparam logic [1:0] PART_OUT   = 2'd2;
	localparam logic [1:0] PART_NONE  = 2'd3;

	// result sources
	localparam logic [1:0] SRC_INTERP = 2'd0;
	localparam logic [1:0] SRC_BEFORE = 2'd1;
	localparam logic [1:0] SRC_AFTER  = 2'd2;
	localparam logic [1:0] SRC_EMPTY  = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [5:0]         key_index;
		logic [1:0]         part;
		logic [31:0]        key_time;
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
	} kts_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [1:0]         source;
	} kts_result_t;

	// three components, index 0 is x
	typedef logic [2:0][31:0] kts_vec_t;

	// control from the sequencer to an arithmetic unit
	typedef struct packed {
		logic start;
		logic cubic;
	} kts_op_t;

endpackage

// File: rtl/kts_ram.sv
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps
module kts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/kts_div.sv
// restoring divider for the interpolation fraction, one quotient bit per cycle
`timescale 1ns / 1ps
module kts_div import kts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          num,
	input  logic [31:0]          den,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quot
);

	localparam int CW = $clog2(FRAC_BITS + 1);

	logic [32:0]          rem_q;
	logic [31:0]          den_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [32:0]          shifted;
	logic                 fits;

	// num < den, so the remainder stays below 2^32 before the shift
	assign shifted = {rem_q[31:0], 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/kts_arith.sv
// linear and hermite evaluation on one shared registered multiplier
`timescale 1ns / 1ps
module kts_arith import kts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kts_op_t              op,
	input  logic [FRAC_BITS-1:0] u,
	input  logic [31:0]          dt,
	input  kts_vec_t             p0,
	input  kts_vec_t             p1,
	input  kts_vec_t             m0,
	input  kts_vec_t             m1,
	output logic                 done,
	output kts_vec_t             res
);

	localparam logic signed [19:0] ONE = 20'sd1 <<< FRAC_BITS;

	logic               run_q;
	logic               half_q;
	logic               cubic_q;
	logic [1:0]         pre_q;
	logic [1:0]         comp_q;
	logic [2:0]         j_q;
	logic               done_q;
	logic signed [16:0] u2_q;
	logic signed [16:0] u3_q;
	logic signed [33:0] tmp_q;
	logic signed [51:0] acc_q;
	logic signed [67:0] prod_q;
	kts_vec_t           res_q;

	logic signed [33:0] opa;
	logic signed [33:0] opb;
	logic signed [33:0] u_s;
	logic signed [33:0] dt_s;
	logic signed [19:0] h00;
	logic signed [19:0] h10;
	logic signed [19:0] h01;
	logic signed [19:0] h11;
	logic signed [19:0] u2e;
	logic signed [19:0] u3e;
	logic signed [19:0] ue;
	logic signed [51:0] sh;
	logic signed [33:0] p0c;
	logic signed [33:0] p1c;
	logic signed [33:0] m0c;
	logic signed [33:0] m1c;
	logic               last_op;

	function automatic logic [31:0] sat32(input logic signed [51:0] x);
		if (x > 52'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (x < -52'sd2147483648) begin
			return 32'h8000_0000;
		end
		return x[31:0];
	endfunction

	assign u_s  = {{(34 - FRAC_BITS){1'b0}}, u};
	assign dt_s = {2'b00, dt};
	assign ue   = {{(20 - FRAC_BITS){1'b0}}, u};
	assign u2e  = {{3{u2_q[16]}}, u2_q};
	assign u3e  = {{3{u3_q[16]}}, u3_q};
	assign h00  = 20'sd2 * u3e - 20'sd3 * u2e + ONE;
	assign h10  = u3e - 20'sd2 * u2e + ue;
	assign h01  = 20'sd3 * u2e - 20'sd2 * u3e;
	assign h11  = u3e - u2e;

	assign p0c = {{2{p0[comp_q][31]}}, p0[comp_q]};
	assign p1c = {{2{p1[comp_q][31]}}, p1[comp_q]};
	assign m0c = {{2{m0[comp_q][31]}}, m0[comp_q]};
	assign m1c = {{2{m1[comp_q][31]}}, m1[comp_q]};

	always_comb begin
		opa = u_s;
		opb = u_s;
		if (pre_q == 2'd0) begin
			opa = u_s;
			opb = u_s;
		end else if (pre_q == 2'd1) begin
			opa = {{17{u2_q[16]}}, u2_q};
			opb = u_s;
		end else if (!cubic_q) begin
			opa = u_s;
			opb = p1c - p0c;
		end else begin
			case (j_q)
				3'd0:    begin opa = 34'(h00); opb = p0c; end
				3'd1:    begin opa = 34'(h10); opb = m0c; end
				3'd3:    begin opa = 34'(h01); opb = p1c; end
				3'd4:    begin opa = 34'(h11); opb = m1c; end
				default: begin opa = tmp_q;    opb = dt_s; end
			endcase
		end
	end

	assign sh      = prod_q[67:FRAC_BITS];
	assign last_op = !cubic_q || (j_q == 3'd5);

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			half_q  <= 1'b0;
			done_q  <= 1'b0;
			pre_q   <= 2'd2;
			comp_q  <= 2'd0;
			j_q     <= 3'd0;
			cubic_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (op.start) begin
				run_q   <= 1'b1;
				half_q  <= 1'b0;
				cubic_q <= op.cubic;
				pre_q   <= op.cubic ? 2'd0 : 2'd2;
				comp_q  <= 2'd0;
				j_q     <= 3'd0;
			end else if (run_q) begin
				half_q <= !half_q;
				if (half_q) begin
					if (pre_q != 2'd2) begin
						pre_q <= pre_q + 2'd1;
					end else if (last_op) begin
						j_q <= 3'd0;
						if (comp_q == 2'd2) begin
							run_q  <= 1'b0;
							done_q <= 1'b1;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && half_q) begin
			if (pre_q == 2'd0) begin
				u2_q <= sh[16:0];
			end else if (pre_q == 2'd1) begin
				u3_q <= sh[16:0];
			end else if (!cubic_q) begin
				res_q[comp_q] <= sat32({{18{p0c[33]}}, p0c} + sh);
			end else begin
				case (j_q)
					3'd0:    acc_q <= sh;
					3'd1,
					3'd4:    tmp_q <= sh[33:0];
					3'd5:    res_q[comp_q] <= sat32(acc_q + sh);
					default: acc_q <= acc_q + sh;
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: rtl/keyframe_track_sampler.sv
// top level: key tables, search sequencer, result register
`timescale 1ns / 1ps
// channel  | signals                          | moves
// item     | item_valid item_ready item       | one load or query request
// result   | result_valid result_ready result | one sampled vector per query
// config   | cfg_we cfg_index cfg_data        | register write, no wait
//
// a load is written when accepted; a query on an empty table goes straight to the
// result; outside the key range it copies an end key's value; inside it a binary
// search runs, then a fraction divide and shared multiplies, linear or cubic
// reset sets interp_mode 1, key_count 0, channel_kind 0; key tables hold
// nothing until loaded
// a held result does not block the next request; only the next finished
// result waits for the result register to empty
module keyframe_track_sampler import kts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  kts_item_t   item,
	output logic        result_valid,
	input  logic        result_ready,
	output kts_result_t result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_T0   = 4'd1;   // read first key time
	localparam logic [3:0] ST_T1   = 4'd2;   // read last key time
	localparam logic [3:0] ST_CHK  = 4'd3;   // range checks
	localparam logic [3:0] ST_SR   = 4'd4;   // search step, issue probe
	localparam logic [3:0] ST_SRD  = 4'd5;   // search step, narrow bracket
	localparam logic [3:0] ST_DEC  = 4'd6;   // exact hit / step / interpolate
	localparam logic [3:0] ST_CP   = 4'd7;   // read a single key value
	localparam logic [3:0] ST_CPD  = 4'd8;
	localparam logic [3:0] ST_FET  = 4'd9;   // fetch both keys' vectors
	localparam logic [3:0] ST_DIV  = 4'd10;
	localparam logic [3:0] ST_ARI  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	localparam logic [31:0] FIX_ONE = 32'd1 << FRAC_BITS;

	// config registers
	logic [1:0]       interp_mode_q;
	logic [CNT_W-1:0] key_count_q;
	logic             channel_kind_q;

	logic [3:0]        state_q;
	logic [31:0]       t_q;
	logic [CNT_W-1:0]  n_q;
	logic [31:0]       t_lo_q;
	logic [31:0]       t_hi_q;
	logic [KEY_AW-1:0] lo_q;
	logic [KEY_AW-1:0] hi_q;
	logic [KEY_AW-1:0] mid_q;
	logic [KEY_AW-1:0] cp_key_q;
	logic [2:0]        fcnt_q;
	logic [31:0]       dt_q;
	kts_vec_t          p0_q;
	kts_vec_t          p1_q;
	kts_vec_t          m0_q;
	kts_vec_t          m1_q;
	kts_vec_t          res_q;
	logic [1:0]        src_q;
	logic              out_valid_q;
	kts_result_t       out_q;

	logic [CNT_W-1:0]  n_eff;
	logic [KEY_AW-1:0] last_key;
	logic [KEY_AW:0]   mid_sum;
	logic [KEY_AW-1:0] mid;
	logic              accept;
	logic              load_ok;
	logic              out_free;

	// table ports
	logic [KEY_AW-1:0] t_raddr;
	logic [31:0]       t_rdata;
	logic [VEC_AW-1:0] v_raddr;
	logic [VEC_AW-1:0] v_waddr;
	logic [95:0]       v_rdata;

	logic                 div_start;
	logic                 div_done;
	logic [FRAC_BITS-1:0] div_quot;
	kts_op_t              ari_op;
	logic                 ari_done;
	kts_vec_t             ari_res;

	// entry key*3+part of the vector table
	function automatic logic [VEC_AW-1:0] vaddr(input logic [KEY_AW-1:0] key,
	                                            input logic [1:0] part);
		return VEC_AW'({key, 1'b0}) + VEC_AW'(key) + VEC_AW'(part);
	endfunction

	assign n_eff    = (key_count_q > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_q;
	assign last_key = KEY_AW'(n_q - CNT_W'(1));
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[KEY_AW:1];
	assign out_free = !out_valid_q || result_ready;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign load_ok    = accept && (item.kind == KIND_LOAD) && (item.part != PART_NONE);
	assign v_waddr    = vaddr(item.key_index, item.part);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_mode_q  <= 2'd1;
			key_count_q    <= '0;
			channel_kind_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERP_MODE:  interp_mode_q  <= cfg_data[1:0];
				REG_KEY_COUNT:    key_count_q    <= cfg_data;
				REG_CHANNEL_KIND: channel_kind_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// read address selection per state
	always_comb begin
		t_raddr = '0;
		v_raddr = vaddr(cp_key_q, PART_VALUE);
		case (state_q)
			ST_T1:   t_raddr = last_key;
			ST_SR:   t_raddr = mid;
			ST_FET: begin
				case (fcnt_q)
					3'd0:    v_raddr = vaddr(lo_q, PART_VALUE);
					3'd1:    v_raddr = vaddr(hi_q, PART_VALUE);
					3'd2:    v_raddr = vaddr(lo_q, PART_OUT);
					default: v_raddr = vaddr(hi_q, PART_IN);
				endcase
			end
			default: ;
		endcase
	end

	kts_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
		.clk   (clk),
		.we    (load_ok),
		.waddr (item.key_index),
		.wdata (item.key_time),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	kts_ram #(.WIDTH(96), .DEPTH(VEC_DEPTH)) u_vectors (
		.clk   (clk),
		.we    (load_ok),
		.waddr (v_waddr),
		.wdata ({item.comp_z, item.comp_y, item.comp_x}),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	assign div_start = (state_q == ST_FET) && (fcnt_q == 3'd4);

	kts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - t_lo_q),
		.den    (dt_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign ari_op.start = (state_q == ST_DIV) && div_done;
	assign ari_op.cubic = (interp_mode_q == MODE_CUBIC);

	kts_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (ari_op),
		.u      (div_quot),
		.dt     (dt_q),
		.p0     (p0_q),
		.p1     (p1_q),
		.m0     (m0_q),
		.m1     (m1_q),
		.done   (ari_done),
		.res    (ari_res)
	);

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.kind == KIND_QUERY)) begin
						state_q <= (n_eff == '0) ? ST_OUT : ST_T0;
					end
				end
				ST_T0:   state_q <= ST_T1;
				ST_T1:   state_q <= ST_CHK;
				ST_CHK: begin
					if ((t_q < t_lo_q) || (t_q >= t_rdata)) begin
						state_q <= ST_CP;
					end else begin
						state_q <= ST_SR;
					end
				end
				ST_SR:   state_q <= ((hi_q - lo_q) > KEY_AW'(1)) ? ST_SRD : ST_DEC;
				ST_SRD:  state_q <= ST_SR;
				ST_DEC: begin
					fcnt_q <= '0;
					if ((t_lo_q == t_q) || (interp_mode_q == MODE_STEP)) begin
						state_q <= ST_CP;
					end else begin
						state_q <= ST_FET;
					end
				end
				ST_CP:   state_q <= ST_CPD;
				ST_CPD:  state_q <= ST_OUT;
				ST_FET: begin
					fcnt_q <= fcnt_q + 3'd1;
					if (fcnt_q == 3'd4) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV:  state_q <= div_done ? ST_ARI : ST_DIV;
				ST_ARI:  state_q <= ari_done ? ST_OUT : ST_ARI;
				ST_OUT:  state_q <= out_free ? ST_IDLE : ST_OUT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q   <= item.key_time;
				n_q   <= n_eff;
				src_q <= SRC_EMPTY;
				res_q <= {3{channel_kind_q ? 32'd0 : FIX_ONE}};
			end
			ST_T1:   t_lo_q <= t_rdata;
			ST_CHK: begin
				t_hi_q <= t_rdata;
				lo_q   <= '0;
				hi_q   <= last_key;
				if (t_q < t_lo_q) begin
					cp_key_q <= '0;
					src_q    <= SRC_BEFORE;
				end else if (t_q > t_rdata) begin
					cp_key_q <= last_key;
					src_q    <= SRC_AFTER;
				end else begin
					cp_key_q <= last_key;
					src_q    <= SRC_INTERP;
				end
			end
			ST_SR:   mid_q <= mid;
			ST_SRD: begin
				if (t_rdata <= t_q) begin
					lo_q   <= mid_q;
					t_lo_q <= t_rdata;
				end else begin
					hi_q   <= mid_q;
					t_hi_q <= t_rdata;
				end
			end
			ST_DEC: begin
				cp_key_q <= lo_q;
				dt_q     <= t_hi_q - t_lo_q;
			end
			ST_CPD:  res_q <= v_rdata;
			ST_FET: begin
				case (fcnt_q)
					3'd1:    p0_q <= v_rdata;
					3'd2:    p1_q <= v_rdata;
					3'd3:    m0_q <= v_rdata;
					3'd4:    m1_q <= v_rdata;
					default: ;
				endcase
			end
			ST_ARI: begin
				if (ari_done) begin
					res_q <= ari_res;
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_q.out_x  <= res_q[0];
			out_q.out_y  <= res_q[1];
			out_q.out_z  <= res_q[2];
			out_q.source <= src_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// bracket stays ordered while searching
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRD) |-> (lo_q < mid_q) && (mid_q < hi_q))
		else $error("search probe outside bracket");

	// fraction divider only finishes while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished out of turn");

	// arithmetic unit only finishes while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		ari_done |-> (state_q == ST_ARI))
		else $error("arithmetic finished out of turn");

	// empty table query goes straight to the result with the empty source
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.kind == KIND_QUERY) && (n_eff == '0))
		|=> (state_q == ST_OUT) && (src_q == SRC_EMPTY))
		else $error("empty table query mishandled");

	// interpolation only runs with a nonzero key spacing
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (dt_q != '0))
		else $error("zero key spacing at divide");

endmodule

// File: tb/sv/keyframe_track_sampler_tb.sv
// testbench for the keyframe track sampler: predicted results checked in order
`timescale 1ns / 1ps
module keyframe_track_sampler_tb;
	import kts_pkg::*;

	localparam int LIMIT   = 1000000;
	localparam int SPACING = 1 << 20;   // gap between sorted key times
	localparam int SETTLE  = 100;       // cycles after the last result before a register write

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	kts_item_t   item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	kts_result_t result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	// no random idling on either side while set
	bit calm = 1'b0;
	int cycles = 0;

	// sampler predictor and store of expected sampled vectors
	class sample_board;
		logic [1:0]  mode = 2'd1;
		logic [6:0]  count = '0;
		logic        chan = 1'b0;
		logic [31:0] times [MAX_KEYS];
		longint      vecs [3*MAX_KEYS][3];
		kts_result_t pending [$];
		int          errors = 0;

		function void write_reg(logic [1:0] idx, logic [6:0] val);
			case (idx)
				REG_INTERP_MODE:  mode = val[1:0];
				REG_KEY_COUNT:    count = val;
				REG_CHANNEL_KIND: chan = val[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] clip(longint x);
			if (x > 64'sd2147483647) return 32'h7fff_ffff;
			if (x < -64'sd2147483648) return 32'h8000_0000;
			return x[31:0];
		endfunction

		// floor of x / 2^FRAC_BITS
		function longint fl(longint x);
			return x >>> FRAC_BITS;
		endfunction

		function kts_result_t sample(logic [31:0] t);
			kts_result_t r;
			longint res [3];
			int unsigned n, lo, hi, mid;
			longint dt, d, u, u2, u3, h00, h10, h01, h11;
			r.source = SRC_INTERP;
			n = (count > MAX_KEYS) ? MAX_KEYS : count;
			if (n == 0) begin
				for (int c = 0; c < 3; c++) res[c] = chan ? 0 : (64'sd1 << FRAC_BITS);
				r.source = SRC_EMPTY;
			end else if (t < times[0]) begin
				for (int c = 0; c < 3; c++) res[c] = vecs[1][c];
				r.source = SRC_BEFORE;
			end else if (t >= times[n-1]) begin
				for (int c = 0; c < 3; c++) res[c] = vecs[(n-1)*3 + 1][c];
				if (t != times[n-1]) r.source = SRC_AFTER;
			end else begin
				lo = 0;
				hi = n - 1;
				while (hi - lo > 1) begin
					mid = (lo + hi) / 2;
					if (times[mid] <= t) lo = mid;
					else hi = mid;
				end
				if (times[lo] == t || mode == MODE_STEP) begin
					for (int c = 0; c < 3; c++) res[c] = vecs[lo*3 + 1][c];
				end else begin
					dt = longint'(times[hi]) - longint'(times[lo]);
					d  = longint'(t) - longint'(times[lo]);
					u  = (d << FRAC_BITS) / dt;
					if (mode == MODE_CUBIC) begin
						u2  = fl(u * u);
						u3  = fl(u2 * u);
						h00 = 2*u3 - 3*u2 + (64'sd1 << FRAC_BITS);
						h10 = u3 - 2*u2 + u;
						h01 = 3*u2 - 2*u3;
						h11 = u3 - u2;
						for (int c = 0; c < 3; c++)
							res[c] = fl(h00 * vecs[lo*3 + 1][c])
								+ fl(fl(h10 * vecs[lo*3 + 2][c]) * dt)
								+ fl(h01 * vecs[hi*3 + 1][c])
								+ fl(fl(h11 * vecs[hi*3][c]) * dt);
					end else begin
						for (int c = 0; c < 3; c++)
							res[c] = vecs[lo*3 + 1][c]
								+ fl(u * (vecs[hi*3 + 1][c] - vecs[lo*3 + 1][c]));
					end
				end
			end
			r.out_x = clip(res[0]);
			r.out_y = clip(res[1]);
			r.out_z = clip(res[2]);
			return r;
		endfunction

		function void note_request(kts_item_t it);
			if (it.kind == KIND_LOAD) begin
				if (it.part != PART_NONE) begin
					times[it.key_index] = it.key_time;
					vecs[it.key_index*3 + it.part][0] = longint'(it.comp_x);
					vecs[it.key_index*3 + it.part][1] = longint'(it.comp_y);
					vecs[it.key_index*3 + it.part][2] = longint'(it.comp_z);
				end
			end else begin
				pending.push_back(sample(it.key_time));
			end
		endfunction

		function void check_result(kts_result_t got);
			kts_result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.out_x !== want.out_x || got.out_y !== want.out_y
				|| got.out_z !== want.out_z || got.source !== want.source) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: want x %h y %h z %h src %0d, got x %h y %h z %h src %0d",
						want.out_x, want.out_y, want.out_z, want.source,
						got.out_x, got.out_y, got.out_z, got.source);
			end
		endfunction
	endclass

	sample_board board = new();

	keyframe_track_sampler u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("keyframe_track_sampler_tb: errors");
			$finish;
		end
	end

	// result side: check on handshake, stall about 30 percent unless calm
	always @(posedge clk) begin
		if (result_valid && result_ready) board.check_result(result);
		result_ready <= calm || ($urandom_range(99) >= 30);
	end

	// one request; valid stays high across back-to-back requests
	task automatic send(kts_item_t it);
		int gap;
		gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		board.note_request(it);
	endtask

	task automatic load(logic [5:0] k, logic [1:0] p, logic [31:0] t);
		kts_item_t it;
		it.kind = KIND_LOAD;
		it.key_index = k;
		it.part = p;
		it.key_time = t;
		it.comp_x = $urandom;
		it.comp_y = $urandom;
		it.comp_z = $urandom;
		// small values now and then so interpolation stays mostly in range
		if ($urandom_range(1)) begin
			it.comp_x = $signed(it.comp_x) >>> 8;
			it.comp_y = $signed(it.comp_y) >>> 8;
			it.comp_z = $signed(it.comp_z) >>> 8;
		end
		send(it);
	endtask

	task automatic query(logic [31:0] t);
		kts_item_t it;
		it = '0;
		it.kind = KIND_QUERY;
		it.key_index = 6'($urandom);
		it.part = 2'($urandom);
		it.key_time = t;
		it.comp_x = $urandom;
		it.comp_y = $urandom;
		it.comp_z = $urandom;
		send(it);
	endtask

	// a whole well-formed key: same sorted time on all three parts
	task automatic load_key(int k);
		logic [31:0] t;
		t = k * SPACING + $urandom_range(0, SPACING - 1);
		load(6'(k), PART_IN, t);
		load(6'(k), PART_VALUE, t);
		load(6'(k), PART_OUT, t);
	endtask

	// drain all results, let the block settle, then write one register
	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, val);
	endtask

	// query time picked to hit each region of the current table
	function automatic logic [31:0] pick_time();
		int unsigned n, k;
		n = (board.count > MAX_KEYS) ? MAX_KEYS : board.count;
		if (n == 0) return $urandom;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(7))
			0: return (board.times[0] > 0) ? $urandom_range(0, board.times[0] - 1) : 32'd0;
			1: return board.times[k];
			2: return board.times[n-1] + $urandom_range(1, 1000);
			3: return $urandom;
			default: return board.times[k] + $urandom_range(0, SPACING);
		endcase
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table in both channel kinds, time extremes
		calm = 1'b1;
		query(32'd0);
		query(32'hffff_ffff);
		write_reg(REG_CHANNEL_KIND, 7'd1);
		query(32'h8000_0000);
		write_reg(2'd3, 7'd5);   // unused index, ignored
		write_reg(REG_CHANNEL_KIND, 7'd0);

		// fill every slot once so no query can touch an unwritten entry
		for (int k = 0; k < MAX_KEYS; k++) load_key(k);
		load(6'd63, PART_NONE, 32'hffff_ffff);   // ignored part

		// directed: step, linear, cubic, odd mode, full and oversized count
		write_reg(REG_KEY_COUNT, 7'd1);
		query(32'd0);
		query(board.times[0]);
		query(32'hffff_ffff);
		write_reg(REG_KEY_COUNT, 7'd64);
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_INTERP_MODE, 7'(m));
			query(board.times[0]);
			query(board.times[10] + SPACING / 3);
			query(board.times[63]);
		end
		write_reg(REG_KEY_COUNT, 7'd127);
		query(board.times[40] + 5);
		query(32'hffff_ffff);

		// random phases; the first runs with no idling at all
		for (int p = 0; p < 7; p++) begin
			calm = (p == 0);
			write_reg(REG_INTERP_MODE, 7'($urandom_range(3)));
			case ($urandom_range(5))
				0: write_reg(REG_KEY_COUNT, 7'd2);
				1: write_reg(REG_KEY_COUNT, 7'd64);
				2: write_reg(REG_KEY_COUNT, 7'($urandom_range(65, 127)));
				3: write_reg(REG_KEY_COUNT, 7'd0);
				default: write_reg(REG_KEY_COUNT, 7'($urandom_range(1, 64)));
			endcase
			write_reg(REG_CHANNEL_KIND, 7'($urandom_range(1)));
			for (int i = 0; i < 36; i++) begin
				case ($urandom_range(15))
					0, 1: load_key($urandom_range(0, MAX_KEYS - 1));
					// noise: lone part with a time that may break the order
					2: load(6'($urandom), 2'($urandom_range(0, 2)),
						$urandom_range(0, (1 << 28) - 1));
					3: load(6'($urandom), PART_NONE, $urandom);
					default: query(pick_time());
				endcase
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0)
			$display("keyframe_track_sampler_tb: clean");
		else
			$display("keyframe_track_sampler_tb: errors");
		$finish;
	end

endmodule
